>>> design/qcs_pkg.sv
package qcs_pkg;

	localparam int SHARES     = 8;
	localparam int PRIORITIES = 4;
	localparam int LIST_N     = 2 * PRIORITIES;

	localparam int ID_W   = $clog2(SHARES);
	localparam int LINK_W = $clog2(SHARES + 1);
	localparam int LIST_W = $clog2(LIST_N);
	localparam int OWN_W  = $clog2(LIST_N + 1);
	localparam int PRIO_W = 2;
	localparam int CUR_W  = 4;
	localparam int IDX_W  = (ID_W > $clog2(PRIORITIES)) ? ID_W : $clog2(PRIORITIES);

	localparam logic [LINK_W-1:0] NIL      = LINK_W'(SHARES);
	localparam logic [OWN_W-1:0]  NO_OWNER = OWN_W'(LIST_N);
	localparam logic [CUR_W-1:0]  IDLE_ID  = CUR_W'(SHARES);
	localparam logic [CUR_W-1:0]  NONE_ID  = CUR_W'(SHARES + 1);

	localparam logic [31:0] RST_SUPER_PERIOD = 32'd1000000;
	localparam logic [31:0] RST_FILL_QUANTUM = 32'd10000;

	localparam logic REG_SUPER_PERIOD = 1'b0;
	localparam logic REG_FILL_QUANTUM = 1'b1;

	typedef enum logic [2:0] {
		K_UPDATE  = 3'd0,
		K_READY   = 3'd1,
		K_UNREADY = 3'd2,
		K_YIELD   = 3'd3,
		K_REMOVE  = 3'd4,
		K_INSERT  = 3'd5,
		K_QUOTA   = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		SCH_UTD   = 2'd0,
		SCH_OOD   = 2'd1,
		SCH_YIELD = 2'd2
	} sched_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LATCH,
		OP_READY,
		OP_UNREADY,
		OP_YIELD,
		OP_CLEAR,
		OP_INSERT,
		OP_QUOTA,
		OP_DUR,
		OP_RCALC,
		OP_CHARGE,
		OP_PERIOD,
		OP_REFILL,
		OP_SCAN,
		OP_PICK_FILL,
		OP_REM,
		OP_REM_OWN,
		OP_INS,
		OP_EMIT
	} dp_op_t;

	typedef enum logic {
		CH_CLAIM,
		CH_FILL
	} chain_sel_t;

	typedef enum logic [1:0] {
		LI_RCL,
		LI_UCL,
		LI_OWN
	} li_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_READY,
		ST_RFILL,
		ST_UNREADY,
		ST_UFREM,
		ST_URET,
		ST_MCREM,
		ST_MCLEAR,
		ST_YIELD,
		ST_INSERT,
		ST_QSTART,
		ST_QFIELDS,
		ST_DUR,
		ST_RCALC,
		ST_CHARGE,
		ST_CLM,
		ST_CLM2,
		ST_PERIOD,
		ST_REFILL,
		ST_SCAN,
		ST_PFILL,
		ST_DONE,
		ST_PUT_REM,
		ST_PUT_INS,
		ST_REM
	} ctl_state_t;

	typedef struct packed {
		dp_op_t     op;
		chain_sel_t chain;
		li_sel_t    li;
		logic       head;
		logic       subj_cur;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       sid_ok;
		logic       present;
		logic       ready;
		logic       quota_nz;
		logic       claim_nz;
		logic       q_in_nz;
		logic       cur_share;
		logic       cur_claim_nz;
		logic       cur_quota_nz;
		logic       cur_ready;
		logic       fill_head_cur;
		logic       r_nz;
		logic       yielded;
		logic       period_gt_dur;
		logic       idx_last;
		logic       idx_zero;
		logic       scan_hit;
	} dp_stat_t;

	typedef struct packed {
		chain_sel_t chain;
		li_sel_t    li;
		logic       head;
		logic       subj_cur;
		ctl_state_t ret;
	} call_t;

endpackage

>>> design/qcs_datapath.sv
module qcs_datapath
	import qcs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  dp_cmd_t      cmd,
	output dp_stat_t     stat,
	input  logic         cfg_we,
	input  logic         cfg_sel,
	input  logic [31:0]  cfg_wdata,
	input  logic [2:0]   in_kind,
	input  logic [2:0]   in_share_id,
	input  logic [63:0]  in_time_stamp,
	input  logic [1:0]   in_priority_req,
	input  logic [31:0]  in_quota_ticks,
	output logic [3:0]   out_current_share,
	output logic [31:0]  out_current_quantum,
	output logic         out_needs_update,
	output logic         out_yield_pending
);

	logic [31:0] cfg_period_q, cfg_fill_q;

	logic [2:0]  kind_q;
	logic [2:0]  sid_q;
	logic [63:0] ts_q;
	logic [1:0]  prio_in_q;
	logic [31:0] quota_in_q;

	logic [31:0]       claim_q   [SHARES];
	logic [31:0]       quota_q   [SHARES];
	logic [31:0]       fillv_q   [SHARES];
	logic [PRIO_W-1:0] prio_q    [SHARES];
	logic              ready_q   [SHARES];
	logic              present_q [SHARES];

	logic [LINK_W-1:0] cnext_q [SHARES];
	logic [LINK_W-1:0] cprev_q [SHARES];
	logic [OWN_W-1:0]  cown_q  [SHARES];
	logic [LINK_W-1:0] chead_q [LIST_N];
	logic [LINK_W-1:0] ctail_q [LIST_N];

	logic [LINK_W-1:0] fnext_q [SHARES];
	logic [LINK_W-1:0] fprev_q [SHARES];
	logic              fin_q   [SHARES];
	logic [LINK_W-1:0] fhead_q, ftail_q;

	logic [63:0]      last_q;
	logic [31:0]      period_q;
	logic [CUR_W-1:0] cur_q;
	logic [31:0]      quantum_q;
	sched_t           sched_q;
	logic [31:0]      dur_q;
	logic [31:0]      r_q;
	logic [IDX_W-1:0] idx_q;

	// subject of the current step and its list indexes
	logic [ID_W-1:0]   s_idx, cur_i, scan_i;
	logic [LINK_W-1:0] s_link;
	logic [LIST_W-1:0] rcl_li, ucl_li, tgt_li, c_rm_li, scan_li;
	logic [OWN_W-1:0]  c_own;
	logic              c_rm_ok;
	logic [LINK_W-1:0] c_n, c_p, c_hd, c_tl, f_n, f_p, scan_h;
	logic              ready_ood, cur_match;
	logic [31:0]       d0, d1, d2;
	logic [PRIO_W-1:0] prio_sat;

	always_comb begin
		cur_i   = cur_q[ID_W-1:0];
		s_idx   = cmd.subj_cur ? cur_i : sid_q[ID_W-1:0];
		s_link  = LINK_W'(s_idx);
		rcl_li  = LIST_W'(prio_q[s_idx]);
		ucl_li  = LIST_W'(PRIORITIES) + LIST_W'(prio_q[s_idx]);
		case (cmd.li)
			LI_RCL:  tgt_li = rcl_li;
			LI_UCL:  tgt_li = ucl_li;
			default: tgt_li = ready_q[s_idx] ? rcl_li : ucl_li;
		endcase
		c_own   = cown_q[s_idx];
		c_rm_ok = (cmd.op == OP_REM) ? (c_own == OWN_W'(tgt_li)) : (c_own != NO_OWNER);
		c_rm_li = c_own[LIST_W-1:0];
		c_n     = cnext_q[s_idx];
		c_p     = cprev_q[s_idx];
		c_hd    = chead_q[tgt_li];
		c_tl    = ctail_q[tgt_li];
		f_n     = fnext_q[s_idx];
		f_p     = fprev_q[s_idx];
		scan_li = LIST_W'(idx_q);
		scan_h  = chead_q[scan_li];
		scan_i  = scan_h[ID_W-1:0];
		cur_match = (cur_q == CUR_W'(s_idx));

		// preemption check of a share that turns ready
		ready_ood = (cur_q >= CUR_W'(SHARES));
		if (quota_q[s_idx] != 32'd0 && claim_q[s_idx] != 32'd0) begin
			if (cur_q < CUR_W'(SHARES) && claim_q[cur_i] != 32'd0) begin
				if (prio_q[s_idx] >= prio_q[cur_i])
					ready_ood = 1'b1;
			end else begin
				ready_ood = 1'b1;
			end
		end

		d0 = ts_q[31:0] - last_q[31:0];
		d1 = (d0 > quantum_q) ? quantum_q : d0;
		d2 = (d1 > period_q) ? period_q : d1;

		prio_sat = (32'(prio_in_q) >= PRIORITIES) ? PRIO_W'(PRIORITIES - 1) : prio_in_q;

		stat.kind          = kind_q;
		stat.sid_ok        = (32'(sid_q) < SHARES);
		stat.present       = present_q[s_idx];
		stat.ready         = ready_q[s_idx];
		stat.quota_nz      = (quota_q[s_idx] != 32'd0);
		stat.claim_nz      = (claim_q[s_idx] != 32'd0);
		stat.q_in_nz       = (quota_in_q != 32'd0);
		stat.cur_share     = (cur_q < CUR_W'(SHARES));
		stat.cur_claim_nz  = (claim_q[cur_i] != 32'd0);
		stat.cur_quota_nz  = (quota_q[cur_i] != 32'd0);
		stat.cur_ready     = ready_q[cur_i];
		stat.fill_head_cur = (fhead_q == LINK_W'(cur_i));
		stat.r_nz          = (r_q != 32'd0);
		stat.yielded       = (sched_q == SCH_YIELD);
		stat.period_gt_dur = (period_q > dur_q);
		stat.idx_last      = (idx_q == IDX_W'(SHARES - 1));
		stat.idx_zero      = (idx_q == '0);
		stat.scan_hit      = (scan_h != NIL) && (claim_q[scan_i] != 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_period_q <= RST_SUPER_PERIOD;
			cfg_fill_q   <= RST_FILL_QUANTUM;
			for (int i = 0; i < SHARES; i++) begin
				claim_q[i]   <= '0;
				quota_q[i]   <= '0;
				fillv_q[i]   <= '0;
				prio_q[i]    <= '0;
				ready_q[i]   <= 1'b0;
				present_q[i] <= 1'b0;
				cnext_q[i]   <= NIL;
				cprev_q[i]   <= NIL;
				cown_q[i]    <= NO_OWNER;
				fnext_q[i]   <= NIL;
				fprev_q[i]   <= NIL;
				fin_q[i]     <= 1'b0;
			end
			for (int j = 0; j < LIST_N; j++) begin
				chead_q[j] <= NIL;
				ctail_q[j] <= NIL;
			end
			fhead_q   <= NIL;
			ftail_q   <= NIL;
			last_q    <= '0;
			period_q  <= '0;
			cur_q     <= IDLE_ID;
			quantum_q <= RST_FILL_QUANTUM;
			sched_q   <= SCH_UTD;
			dur_q     <= '0;
			r_q       <= '0;
			idx_q     <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_sel == REG_SUPER_PERIOD)
					cfg_period_q <= cfg_wdata;
				else
					cfg_fill_q <= cfg_wdata;
			end
			case (cmd.op)
				OP_READY: begin
					ready_q[s_idx] <= 1'b1;
					fillv_q[s_idx] <= cfg_fill_q;
					if (ready_ood && sched_q == SCH_UTD)
						sched_q <= SCH_OOD;
				end
				OP_UNREADY: begin
					if (cur_match && sched_q == SCH_UTD)
						sched_q <= SCH_OOD;
					ready_q[s_idx] <= 1'b0;
				end
				OP_YIELD: sched_q <= SCH_YIELD;
				OP_CLEAR: begin
					if (cur_match)
						cur_q <= NONE_ID;
					present_q[s_idx] <= 1'b0;
					claim_q[s_idx]   <= '0;
					quota_q[s_idx]   <= '0;
					fillv_q[s_idx]   <= '0;
					prio_q[s_idx]    <= '0;
				end
				OP_INSERT: begin
					present_q[s_idx] <= 1'b1;
					ready_q[s_idx]   <= 1'b0;
					prio_q[s_idx]    <= prio_sat;
					quota_q[s_idx]   <= quota_in_q;
					claim_q[s_idx]   <= quota_in_q;
					fillv_q[s_idx]   <= '0;
				end
				OP_QUOTA: begin
					if (quota_q[s_idx] != 32'd0 && claim_q[s_idx] > quota_in_q)
						claim_q[s_idx] <= quota_in_q;
					quota_q[s_idx] <= quota_in_q;
				end
				OP_DUR: begin
					dur_q  <= d2;
					last_q <= ts_q;
				end
				OP_RCALC: r_q <= (sched_q == SCH_YIELD) ? 32'd0 : quantum_q - dur_q;
				OP_CHARGE: begin
					if (cur_q < CUR_W'(SHARES)) begin
						if (claim_q[cur_i] != 32'd0) begin
							if (quota_q[cur_i] != 32'd0)
								claim_q[cur_i] <= (r_q > quota_q[cur_i]) ? quota_q[cur_i] : r_q;
						end else if (fhead_q == LINK_W'(cur_i)) begin
							fillv_q[cur_i] <= (r_q != 32'd0) ? r_q : cfg_fill_q;
						end
					end
				end
				OP_PERIOD: begin
					sched_q <= SCH_UTD;
					if (period_q > dur_q) begin
						period_q <= period_q - dur_q;
						idx_q    <= IDX_W'(PRIORITIES - 1);
					end else begin
						period_q <= cfg_period_q;
						idx_q    <= '0;
					end
				end
				OP_REFILL: begin
					if (cown_q[idx_q[ID_W-1:0]] != NO_OWNER)
						claim_q[idx_q[ID_W-1:0]] <= quota_q[idx_q[ID_W-1:0]];
					idx_q <= (idx_q == IDX_W'(SHARES - 1)) ? IDX_W'(PRIORITIES - 1)
						: idx_q + IDX_W'(1);
				end
				OP_SCAN: begin
					if (scan_h != NIL && claim_q[scan_i] != 32'd0) begin
						cur_q     <= CUR_W'(scan_i);
						quantum_q <= claim_q[scan_i];
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				OP_PICK_FILL: begin
					if (fhead_q != NIL) begin
						cur_q     <= CUR_W'(fhead_q[ID_W-1:0]);
						quantum_q <= fillv_q[fhead_q[ID_W-1:0]];
					end else begin
						cur_q     <= IDLE_ID;
						quantum_q <= cfg_fill_q;
					end
				end
				OP_REM, OP_REM_OWN: begin
					if (cmd.chain == CH_CLAIM) begin
						if (c_rm_ok) begin
							if (c_p == NIL) chead_q[c_rm_li] <= c_n;
							else cnext_q[c_p[ID_W-1:0]] <= c_n;
							if (c_n == NIL) ctail_q[c_rm_li] <= c_p;
							else cprev_q[c_n[ID_W-1:0]] <= c_p;
							cnext_q[s_idx] <= NIL;
							cprev_q[s_idx] <= NIL;
							cown_q[s_idx]  <= NO_OWNER;
						end
					end else if (fin_q[s_idx]) begin
						if (f_p == NIL) fhead_q <= f_n;
						else fnext_q[f_p[ID_W-1:0]] <= f_n;
						if (f_n == NIL) ftail_q <= f_p;
						else fprev_q[f_n[ID_W-1:0]] <= f_p;
						fnext_q[s_idx] <= NIL;
						fprev_q[s_idx] <= NIL;
						fin_q[s_idx]   <= 1'b0;
					end
				end
				OP_INS: begin
					if (cmd.chain == CH_CLAIM) begin
						if (cmd.head) begin
							cprev_q[s_idx] <= NIL;
							cnext_q[s_idx] <= c_hd;
							if (c_hd == NIL) ctail_q[tgt_li] <= s_link;
							else cprev_q[c_hd[ID_W-1:0]] <= s_link;
							chead_q[tgt_li] <= s_link;
						end else begin
							cnext_q[s_idx] <= NIL;
							cprev_q[s_idx] <= c_tl;
							if (c_tl == NIL) chead_q[tgt_li] <= s_link;
							else cnext_q[c_tl[ID_W-1:0]] <= s_link;
							ctail_q[tgt_li] <= s_link;
						end
						cown_q[s_idx] <= OWN_W'(tgt_li);
					end else begin
						if (cmd.head) begin
							fprev_q[s_idx] <= NIL;
							fnext_q[s_idx] <= fhead_q;
							if (fhead_q == NIL) ftail_q <= s_link;
							else fprev_q[fhead_q[ID_W-1:0]] <= s_link;
							fhead_q <= s_link;
						end else begin
							fnext_q[s_idx] <= NIL;
							fprev_q[s_idx] <= ftail_q;
							if (ftail_q == NIL) fhead_q <= s_link;
							else fnext_q[ftail_q[ID_W-1:0]] <= s_link;
							ftail_q <= s_link;
						end
						fin_q[s_idx] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// item capture and result register, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			kind_q     <= in_kind;
			sid_q      <= in_share_id;
			ts_q       <= in_time_stamp;
			prio_in_q  <= in_priority_req;
			quota_in_q <= in_quota_ticks;
		end
		if (cmd.op == OP_EMIT) begin
			out_current_share   <= cur_q;
			out_current_quantum <= quantum_q;
			out_needs_update    <= (sched_q != SCH_UTD);
			out_yield_pending   <= (sched_q == SCH_YIELD);
		end
	end

	// share 0, when outside the claim lists, keeps null links
	a_unlinked_nil: assert property (@(posedge clk) disable iff (!arst_n)
		(cown_q[0] == NO_OWNER) |-> (cnext_q[0] == NIL && cprev_q[0] == NIL))
		else $error("unlinked share 0 has stale claim links");

	// same for the fill list
	a_fill_unlinked_nil: assert property (@(posedge clk) disable iff (!arst_n)
		!fin_q[0] |-> (fnext_q[0] == NIL && fprev_q[0] == NIL))
		else $error("unlinked share 0 has stale fill links");

	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= NONE_ID)
		else $error("current share code out of range");

endmodule

>>> design/qcs_ctrl.sv
module qcs_ctrl
	import qcs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctl_state_t state_q, state_d;
	call_t      call_q, call_d;
	logic       call_load;
	logic       out_valid_q;
	logic       in_accept, emit;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign emit      = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// next state; list moves go through the PUT/REM helper states
	always_comb begin
		state_d   = state_q;
		call_d    = call_q;
		call_load = 1'b0;
		case (state_q)
			ST_IDLE: if (in_accept) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (stat.kind)
					K_UPDATE:  state_d = ST_DUR;
					K_READY:   state_d = (stat.sid_ok && stat.present && !stat.ready)
						? ST_READY : ST_DONE;
					K_UNREADY: state_d = (stat.sid_ok && stat.ready) ? ST_UNREADY : ST_DONE;
					K_YIELD:   state_d = ST_YIELD;
					K_REMOVE:  state_d = !(stat.sid_ok && stat.present) ? ST_DONE
						: (stat.ready ? ST_UNREADY : ST_MCREM);
					K_INSERT:  state_d = (stat.sid_ok && !stat.present) ? ST_INSERT : ST_DONE;
					K_QUOTA:   state_d = (stat.sid_ok && stat.present) ? ST_QSTART : ST_DONE;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_READY: begin
				if (stat.quota_nz) begin
					call_d    = '{CH_CLAIM, LI_RCL, stat.claim_nz, 1'b0, ST_RFILL};
					call_load = 1'b1;
					state_d   = ST_PUT_REM;
				end else begin
					state_d = ST_RFILL;
				end
			end
			ST_RFILL: begin
				call_d    = '{CH_FILL, LI_RCL, 1'b0, 1'b0, ST_DONE};
				call_load = 1'b1;
				state_d   = ST_PUT_REM;
			end
			ST_UNREADY: state_d = ST_UFREM;
			ST_UFREM: begin
				if (stat.quota_nz) begin
					call_d    = '{CH_CLAIM, LI_UCL, 1'b0, 1'b0, ST_URET};
					call_load = 1'b1;
					state_d   = ST_PUT_REM;
				end else begin
					state_d = ST_URET;
				end
			end
			ST_URET:   state_d = (stat.kind == K_REMOVE) ? ST_MCREM : ST_DONE;
			ST_MCREM:  state_d = ST_MCLEAR;
			ST_MCLEAR: state_d = ST_DONE;
			ST_YIELD:  state_d = ST_DONE;
			ST_INSERT: begin
				if (stat.q_in_nz) begin
					call_d    = '{CH_CLAIM, LI_UCL, 1'b1, 1'b0, ST_DONE};
					call_load = 1'b1;
					state_d   = ST_PUT_REM;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_QSTART: begin
				state_d = ST_QFIELDS;
				if (stat.quota_nz && !stat.q_in_nz) begin
					call_d    = '{CH_CLAIM, LI_OWN, 1'b0, 1'b0, ST_QFIELDS};
					call_load = 1'b1;
					state_d   = ST_REM;
				end else if (!stat.quota_nz && stat.q_in_nz) begin
					call_d    = '{CH_CLAIM, LI_OWN, 1'b0, 1'b0, ST_QFIELDS};
					call_load = 1'b1;
					state_d   = ST_PUT_REM;
				end
			end
			ST_QFIELDS: state_d = ST_DONE;
			ST_DUR:     state_d = ST_RCALC;
			ST_RCALC:   state_d = ST_CHARGE;
			ST_CHARGE: begin
				state_d = ST_PERIOD;
				if (stat.cur_share) begin
					if (stat.cur_claim_nz) begin
						if (stat.cur_quota_nz) state_d = ST_CLM;
					end else if (stat.fill_head_cur && !stat.r_nz) begin
						call_d    = '{CH_FILL, LI_RCL, 1'b0, 1'b1, ST_PERIOD};
						call_load = 1'b1;
						state_d   = ST_PUT_REM;
					end
				end
			end
			ST_CLM: begin
				if (!stat.cur_claim_nz && stat.cur_ready) begin
					call_d    = '{CH_CLAIM, LI_RCL, 1'b0, 1'b1, ST_CLM2};
					call_load = 1'b1;
					state_d   = ST_PUT_REM;
				end else begin
					state_d = ST_PERIOD;
				end
			end
			ST_CLM2: begin
				if (!stat.yielded) begin
					call_d    = '{CH_FILL, LI_RCL, 1'b1, 1'b1, ST_PERIOD};
					call_load = 1'b1;
					state_d   = ST_PUT_REM;
				end else begin
					state_d = ST_PERIOD;
				end
			end
			ST_PERIOD: state_d = stat.period_gt_dur ? ST_SCAN : ST_REFILL;
			ST_REFILL: if (stat.idx_last) state_d = ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_hit) state_d = ST_DONE;
				else if (stat.idx_zero) state_d = ST_PFILL;
			end
			ST_PFILL:   state_d = ST_DONE;
			ST_DONE:    if (emit) state_d = ST_IDLE;
			ST_PUT_REM: state_d = ST_PUT_INS;
			ST_PUT_INS: state_d = call_q.ret;
			ST_REM:     state_d = call_q.ret;
			default:    state_d = ST_IDLE;
		endcase
	end

	// datapath command per state
	always_comb begin
		cmd          = '0;
		cmd.chain    = call_q.chain;
		cmd.li       = call_q.li;
		cmd.head     = call_q.head;
		cmd.subj_cur = call_q.subj_cur;
		case (state_q)
			ST_IDLE:      cmd.op = in_accept ? OP_LATCH : OP_NOP;
			ST_READY:     cmd.op = OP_READY;
			ST_UNREADY:   cmd.op = OP_UNREADY;
			ST_UFREM: begin
				cmd.op       = OP_REM;
				cmd.chain    = CH_FILL;
				cmd.subj_cur = 1'b0;
			end
			ST_MCREM: begin
				cmd.op       = OP_REM;
				cmd.chain    = CH_CLAIM;
				cmd.li       = LI_UCL;
				cmd.subj_cur = 1'b0;
			end
			ST_MCLEAR:    cmd.op = OP_CLEAR;
			ST_YIELD:     cmd.op = OP_YIELD;
			ST_INSERT:    cmd.op = OP_INSERT;
			ST_QFIELDS:   cmd.op = OP_QUOTA;
			ST_DUR:       cmd.op = OP_DUR;
			ST_RCALC:     cmd.op = OP_RCALC;
			ST_CHARGE:    cmd.op = OP_CHARGE;
			ST_PERIOD:    cmd.op = OP_PERIOD;
			ST_REFILL:    cmd.op = OP_REFILL;
			ST_SCAN:      cmd.op = OP_SCAN;
			ST_PFILL:     cmd.op = OP_PICK_FILL;
			ST_DONE:      cmd.op = emit ? OP_EMIT : OP_NOP;
			ST_PUT_REM:   cmd.op = OP_REM_OWN;
			ST_PUT_INS:   cmd.op = OP_INS;
			ST_REM:       cmd.op = OP_REM;
			default:      cmd.op = OP_NOP;
		endcase
		// status reads in non-helper states refer to the event's share
		if (state_q != ST_PUT_REM && state_q != ST_PUT_INS && state_q != ST_REM
			&& state_q != ST_UFREM && state_q != ST_MCREM)
			cmd.subj_cur = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			call_q      <= '{CH_CLAIM, LI_RCL, 1'b0, 1'b0, ST_IDLE};
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (call_load)
				call_q <= call_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_EMIT) |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !in_accept) |=> (state_q == ST_IDLE))
		else $error("left idle without an accepted word");

	a_put_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT_REM) |=> (state_q == ST_PUT_INS))
		else $error("list unlink not followed by link");

endmodule

>>> design/quota_claim_cpu_scheduler_core.sv
// Quota/claim CPU scheduler for up to 8 shares at 4 priorities. Each input
// word is one scheduler event (kind in tuser) and yields exactly one result
// word with the current share (0-7, 8 idle, 9 none), its quantum and the
// update/yield flags. Events are handled one at a time by a sequencer over
// a per-share register file and linked ready/unready claim lists and a fill
// list; each list move is an unlink step followed by a link step. An update
// charges the elapsed time to the current share, may move it between lists,
// refills all claims one share per cycle when the super period ends, then
// scans the claim lists from the highest priority down, else picks the fill
// list head or goes idle.
// The next event is taken as soon as the sequencer is back in idle, while
// the previous result may still sit in the output register. Configuration
// (index 0 super period length, index 1 fill quantum) is always ready and
// must be written only while no event is in flight.
module quota_claim_cpu_scheduler_core
	import qcs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [2:0] share_id, [66:3] time_stamp, [68:67] priority_req,
	// [100:69] quota_ticks, [103:101] zero
	input  logic [103:0] s_axis_tdata,
	// [2:0] kind
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [3:0] current_share, [35:4] current_quantum, [36] needs_update,
	// [37] yield_pending, [39:38] zero
	output logic [39:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [3:0]  res_share;
	logic [31:0] res_quantum;
	logic        res_needs_update, res_yield_pending;

	assign cfg_ready = 1'b1;

	qcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	qcs_datapath u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.cfg_we              (cfg_valid && cfg_ready),
		.cfg_sel             (cfg_index),
		.cfg_wdata           (cfg_data),
		.in_kind             (s_axis_tuser),
		.in_share_id         (s_axis_tdata[2:0]),
		.in_time_stamp       (s_axis_tdata[66:3]),
		.in_priority_req     (s_axis_tdata[68:67]),
		.in_quota_ticks      (s_axis_tdata[100:69]),
		.out_current_share   (res_share),
		.out_current_quantum (res_quantum),
		.out_needs_update    (res_needs_update),
		.out_yield_pending   (res_yield_pending)
	);

	assign m_axis_tdata = {2'b00, res_yield_pending, res_needs_update, res_quantum, res_share};

endmodule

>>> test/quota_claim_cpu_scheduler_core_checker.sv
module quota_claim_cpu_scheduler_core_checker
	import qcs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,
	input  logic [2:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [39:0]  m_axis_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           pending,
	output int           results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// members from the highest bit down, matching the result word layout
	typedef struct packed {
		logic        yld;
		logic        upd;
		logic [31:0] quantum;
		logic [3:0]  share;
	} sched_word_t;

	localparam int NL = SHARES;
	localparam int NOOWN = LIST_N;

	logic [31:0] period_len, fq;
	logic [31:0] claim [SHARES];
	logic [31:0] quota [SHARES];
	logic [31:0] fillv [SHARES];
	int          prio [SHARES];
	bit          rdy [SHARES];
	bit          pres [SHARES];
	int          c_next [SHARES], c_prev [SHARES], c_own [SHARES];
	int          f_next [SHARES], f_prev [SHARES], f_own [SHARES];
	int          c_head [LIST_N], c_tail [LIST_N];
	int          f_head, f_tail;
	logic [63:0] last_t;
	logic [31:0] period_left;
	int          cur;
	logic [31:0] qnow;
	sched_t      st;
	sched_word_t schedule_q [$];

	// chain ops; fill chain is selected by isf
	function automatic void unlink(bit isf, int li, int s);
		int n, p;
		if (isf) begin
			if (f_own[s] != li) return;
			n = f_next[s]; p = f_prev[s];
			if (p == NL) f_head = n; else f_next[p] = n;
			if (n == NL) f_tail = p; else f_prev[n] = p;
			f_next[s] = NL; f_prev[s] = NL; f_own[s] = NOOWN;
		end else begin
			if (c_own[s] != li) return;
			n = c_next[s]; p = c_prev[s];
			if (p == NL) c_head[li] = n; else c_next[p] = n;
			if (n == NL) c_tail[li] = p; else c_prev[n] = p;
			c_next[s] = NL; c_prev[s] = NL; c_own[s] = NOOWN;
		end
	endfunction

	function automatic void link(bit isf, int li, int s, bit at_head);
		if (isf) begin
			if (f_own[s] != NOOWN) unlink(1, f_own[s], s);
			if (at_head) begin
				f_prev[s] = NL; f_next[s] = f_head;
				if (f_head == NL) f_tail = s; else f_prev[f_head] = s;
				f_head = s;
			end else begin
				f_next[s] = NL; f_prev[s] = f_tail;
				if (f_tail == NL) f_head = s; else f_next[f_tail] = s;
				f_tail = s;
			end
			f_own[s] = li;
		end else begin
			if (c_own[s] != NOOWN) unlink(0, c_own[s], s);
			if (at_head) begin
				c_prev[s] = NL; c_next[s] = c_head[li];
				if (c_head[li] == NL) c_tail[li] = s; else c_prev[c_head[li]] = s;
				c_head[li] = s;
			end else begin
				c_next[s] = NL; c_prev[s] = c_tail[li];
				if (c_tail[li] == NL) c_head[li] = s; else c_next[c_tail[li]] = s;
				c_tail[li] = s;
			end
			c_own[s] = li;
		end
	endfunction

	function automatic void stale();
		if (st == SCH_UTD) st = SCH_OOD;
	endfunction

	function automatic void make_unready(int s);
		if (s == cur) stale();
		rdy[s] = 0;
		unlink(1, 0, s);
		if (quota[s] == 0) return;
		unlink(0, prio[s], s);
		link(0, PRIORITIES + prio[s], s, 0);
	endfunction

	function automatic void charge_and_pick(logic [63:0] t);
		logic [31:0] dur, r;
		int s;
		dur = 32'(t - last_t);
		if (dur > qnow) dur = qnow;
		if (dur > period_left) dur = period_left;
		last_t = t;
		if (cur < SHARES) begin
			s = cur;
			r = (st != SCH_YIELD) ? qnow - dur : 32'd0;
			if (claim[s] != 0) begin
				if (quota[s] != 0) begin
					claim[s] = (r > quota[s]) ? quota[s] : r;
					if (claim[s] == 0 && rdy[s]) begin
						link(0, prio[s], s, 0);
						if (st != SCH_YIELD) link(1, 0, s, 1);
					end
				end
			end else if (f_head == s) begin
				if (r != 0) fillv[s] = r;
				else begin
					fillv[s] = fq;
					link(1, 0, s, 0);
				end
			end
		end
		if (period_left > dur) period_left -= dur;
		else begin
			period_left = period_len;
			for (int i = 0; i < SHARES; i++)
				if (c_own[i] != NOOWN) claim[i] = quota[i];
		end
		st = SCH_UTD;
		for (int p = PRIORITIES - 1; p >= 0; p--)
			if (c_head[p] != NL && claim[c_head[p]] != 0) begin
				cur = c_head[p];
				qnow = claim[cur];
				return;
			end
		if (f_head != NL) begin
			cur = f_head;
			qnow = fillv[cur];
			return;
		end
		cur = SHARES;
		qnow = fq;
	endfunction

	function automatic void make_ready(int s);
		bit ood;
		ood = 0;
		rdy[s] = 1;
		if (quota[s] != 0) begin
			unlink(0, PRIORITIES + prio[s], s);
			if (claim[s] != 0) begin
				link(0, prio[s], s, 1);
				if (cur < SHARES && claim[cur] != 0) begin
					if (prio[s] >= prio[cur]) ood = 1;
				end else ood = 1;
			end else link(0, prio[s], s, 0);
		end
		fillv[s] = fq;
		link(1, 0, s, 0);
		if (cur >= SHARES) ood = 1;
		if (ood) stale();
	endfunction

	function automatic void drop_share(int s);
		if (rdy[s]) make_unready(s);
		if (s == cur) cur = SHARES + 1;
		if (quota[s] != 0) unlink(0, PRIORITIES + prio[s], s);
		pres[s] = 0; claim[s] = 0; quota[s] = 0; fillv[s] = 0; prio[s] = 0;
	endfunction

	function automatic void change_quota(int s, logic [31:0] q);
		int own;
		own = rdy[s] ? prio[s] : PRIORITIES + prio[s];
		if (quota[s] != 0) begin
			if (claim[s] > q) claim[s] = q;
			if (q == 0) unlink(0, own, s);
		end else if (q != 0) link(0, own, s, 0);
		quota[s] = q;
	endfunction

	function automatic sched_word_t schedule_event(kind_t k, int s, logic [63:0] t,
			int pr, logic [31:0] q);
		sched_word_t w;
		case (k)
			K_UPDATE:  charge_and_pick(t);
			K_READY:   if (pres[s] && !rdy[s]) make_ready(s);
			K_UNREADY: if (rdy[s]) make_unready(s);
			K_YIELD:   st = SCH_YIELD;
			K_REMOVE:  if (pres[s]) drop_share(s);
			K_INSERT:  if (!pres[s]) begin
				pres[s] = 1; rdy[s] = 0; prio[s] = pr;
				quota[s] = q; claim[s] = q; fillv[s] = 0;
				if (q != 0) link(0, PRIORITIES + pr, s, 1);
			end
			K_QUOTA:   if (pres[s]) change_quota(s, q);
			default: ;
		endcase
		w.share = 4'(cur);
		w.quantum = qnow;
		w.upd = (st != SCH_UTD);
		w.yld = (st == SCH_YIELD);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_word_t want, got;
		if (!arst_n) begin
			period_len = RST_SUPER_PERIOD;
			fq = RST_FILL_QUANTUM;
			for (int i = 0; i < SHARES; i++) begin
				claim[i] = 0; quota[i] = 0; fillv[i] = 0; prio[i] = 0;
				rdy[i] = 0; pres[i] = 0;
				c_next[i] = NL; c_prev[i] = NL; c_own[i] = NOOWN;
				f_next[i] = NL; f_prev[i] = NL; f_own[i] = NOOWN;
			end
			for (int i = 0; i < LIST_N; i++) begin
				c_head[i] = NL; c_tail[i] = NL;
			end
			f_head = NL; f_tail = NL;
			last_t = 0; period_left = 0; cur = SHARES; qnow = RST_FILL_QUANTUM;
			st = SCH_UTD;
			schedule_q.delete();
			errors <= 0; pending <= 0; results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SUPER_PERIOD) period_len = cfg_data;
				else fq = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[37:0];
				results_seen <= results_seen + 1;
				if (schedule_q.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = schedule_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch share exp %0d act %0d, quantum exp %0d act %0d, upd exp %0b act %0b, yield exp %0b act %0b",
							$time, want.share, got.share, want.quantum, got.quantum,
							want.upd, got.upd, want.yld, got.yld);
						errors <= errors + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				schedule_q.push_back(schedule_event(kind_t'(s_axis_tuser),
					int'(s_axis_tdata[2:0]), s_axis_tdata[66:3],
					int'(s_axis_tdata[68:67]), s_axis_tdata[100:69]));
			pending <= schedule_q.size();
		end
	end
endmodule

>>> test/quota_claim_cpu_scheduler_core_test.sv
module quota_claim_cpu_scheduler_core_test;
	import qcs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk, arst_n;
	logic         s_axis_tvalid, s_axis_tready;
	logic [103:0] s_axis_tdata;   // [2:0] share_id, [66:3] time_stamp,
	                              // [68:67] priority_req, [100:69] quota_ticks
	logic [2:0]   s_axis_tuser;   // [2:0] kind
	logic         m_axis_tvalid, m_axis_tready;
	logic [39:0]  m_axis_tdata;   // [3:0] share, [35:4] quantum, [36] upd, [37] yield
	logic         cfg_valid, cfg_ready, cfg_index;
	logic [31:0]  cfg_data;
	int           errors, pending, results_seen;
	int           cycles;
	bit           timed_out;
	logic [63:0]  now_ticks;       // running time stamp for updates
	int           stall_pat;

	localparam int CYCLE_LIMIT = 400000;

	quota_claim_cpu_scheduler_core dut (.*);
	quota_claim_cpu_scheduler_core_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Global watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("quota_claim_cpu_scheduler_core test failed");
			$finish;
		end
	end

	// Receiver stalls with a shifting pattern, plus quiet stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
			stall_pat <= 0;
		end else begin
			stall_pat <= stall_pat + 1;
			if ((stall_pat / 256) % 3 == 0) m_axis_tready <= 1;
			else m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// One event word, held valid until it is accepted
	task automatic send_word(kind_t k, logic [2:0] sid, logic [63:0] t,
			logic [1:0] pr, logic [31:0] q);
		s_axis_tvalid <= 1;
		s_axis_tuser <= k;
		s_axis_tdata <= {3'b0, q, pr, t, sid};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic gap();
		s_axis_tvalid <= 0;
		repeat ($urandom_range(1, 12)) @(posedge clk);
	endtask

	task automatic drain_and_config(logic idx, logic [31:0] val);
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	// Random event biased to well-formed scheduler activity
	task automatic random_event();
		int r;
		logic [31:0] q;
		r = $urandom_range(0, 99);
		q = ($urandom_range(0, 9) == 0) ? $urandom :
			(($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 3000));
		if (r < 35) begin
			now_ticks = ($urandom_range(0, 40) == 0) ? {$urandom, $urandom} :
				now_ticks + $urandom_range(0, 4000);
			send_word(K_UPDATE, 3'($urandom), now_ticks, 2'($urandom), $urandom);
		end else if (r < 55) send_word(K_READY, 3'($urandom), {$urandom, $urandom}, 0, 0);
		else if (r < 65) send_word(K_UNREADY, 3'($urandom), 0, 2'($urandom), 0);
		else if (r < 72) send_word(K_YIELD, 3'($urandom), {$urandom, $urandom}, 0, $urandom);
		else if (r < 79) send_word(K_REMOVE, 3'($urandom), 0, 0, 0);
		else if (r < 92) send_word(K_INSERT, 3'($urandom), 0, 2'($urandom), q);
		else send_word(K_QUOTA, 3'($urandom), 0, 0, q);
	endtask

	initial begin
		logic [31:0] periods [4];
		logic [31:0] quanta [4];
		int burst;
		periods = '{32'd1, 32'd5000, 32'hFFFF_FFFF, 32'd20000};
		quanta  = '{32'hFFFF_FFFF, 32'd1, 32'd700, 32'd10000};
		cycles = 0;
		now_ticks = 0;
		arst_n = 0;
		s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
		cfg_valid = 0; cfg_index = 0; cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every kind, ignored cases, clamped elapsed time
		send_word(K_UPDATE, 3'd7, 64'd0, 2'd3, 32'hFFFF_FFFF);
		send_word(K_YIELD, 3'd0, '1, 2'd0, 0);
		send_word(K_INSERT, 3'd7, '1, 2'd3, 32'hFFFF_FFFF);
		send_word(K_INSERT, 3'd7, 0, 2'd0, 32'd5);       // present: ignored
		send_word(K_INSERT, 3'd0, 0, 2'd0, 32'd0);       // no claim
		send_word(K_INSERT, 3'd3, 0, 2'd1, 32'd300);
		send_word(K_READY, 3'd5, 0, 0, 0);               // absent: ignored
		send_word(K_READY, 3'd7, 0, 0, 0);
		send_word(K_READY, 3'd7, 0, 0, 0);               // already ready
		send_word(K_READY, 3'd0, 0, 0, 0);
		send_word(K_READY, 3'd3, 0, 0, 0);
		send_word(K_UPDATE, 0, 64'd100, 0, 0);
		send_word(K_UPDATE, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0); // wraps mod 2^32
		send_word(K_YIELD, 0, 0, 0, 0);
		send_word(K_UPDATE, 0, 64'd50, 0, 0);
		send_word(K_UNREADY, 3'd6, 0, 0, 0);             // not ready: ignored
		send_word(K_UNREADY, 3'd3, 0, 0, 0);
		send_word(K_QUOTA, 3'd4, 0, 0, 32'd9);           // absent: ignored
		send_word(K_QUOTA, 3'd0, 0, 0, 32'd40);
		send_word(K_QUOTA, 3'd7, 0, 0, 32'd0);
		send_word(K_REMOVE, 3'd2, 0, 0, 0);              // absent: ignored
		send_word(K_REMOVE, 3'd7, 0, 0, 0);
		send_word(K_UPDATE, 0, 64'd9000, 0, 0);
		send_word(K_REMOVE, 3'd0, 0, 0, 0);
		send_word(K_UPDATE, 0, 64'd9100, 0, 0);
		now_ticks = 64'd9100;

		// Random phases, each under its own register setting
		for (int ph = 0; ph < 4; ph++) begin
			drain_and_config(REG_SUPER_PERIOD, periods[ph]);
			drain_and_config(REG_FILL_QUANTUM, quanta[ph]);
			for (int n = 0; n < 460; ) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && n < 460; b++, n++) random_event();
				if ($urandom_range(0, 2) != 0) gap();
			end
		end

		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Ran directed scheduler events and four register settings of random");
		$display("events; %0d result words checked.", results_seen);
		if (errors == 0 && pending == 0)
			$display("quota_claim_cpu_scheduler_core test passed");
		else
			$display("quota_claim_cpu_scheduler_core test failed");
		$finish;
	end
endmodule

>>> sim.f
design/qcs_pkg.sv
design/qcs_datapath.sv
design/qcs_ctrl.sv
design/quota_claim_cpu_scheduler_core.sv
test/quota_claim_cpu_scheduler_core_checker.sv
test/quota_claim_cpu_scheduler_core_test.sv
